### design/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types and constants for the I2C master byte engine: command codes,
// engine phases, the tick queue entry and queue sizing.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int unsigned DLY_W     = 16;  // bus delay counter / register width
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 4;   // bit counter width
  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [DLY_W-1:0] TPD_RESET     = 16'd5;

  // tick queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // classified request
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // engine phases, one-hot
  typedef enum logic [15:0] {
    PH_IDLE         = 16'h0001,
    PH_ST_A         = 16'h0002,
    PH_ST_B         = 16'h0004,
    PH_ST_C         = 16'h0008,
    PH_ST_D         = 16'h0010,
    PH_SP_A         = 16'h0020,
    PH_SP_B         = 16'h0040,
    PH_SP_C         = 16'h0080,
    PH_TX_HIGH      = 16'h0100,
    PH_TX_LOW       = 16'h0200,
    PH_TX_ACK       = 16'h0400,
    PH_RX_RAISE     = 16'h0800,
    PH_RX_WAIT      = 16'h1000,
    PH_RX_HIGH      = 16'h2000,
    PH_RX_ACK_RAISE = 16'h4000,
    PH_RX_ACK_HIGH  = 16'h8000
  } phase_t;

  // one queued tick
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              send_ack;
    logic              sda_in;
    logic              scl_in;
  } tick_t;

  // front -> back queue head
  typedef struct packed {
    logic  valid;
    tick_t item;
  } qhead_t;

endpackage

### design/i2cbe_front.sv
// ----------------------------------------------------------------------------
// i2cbe_front
// Accepts tick beats, classifies the request code and queues the tick for
// the engine. Stalls only when the queue is full.
// ----------------------------------------------------------------------------
module i2cbe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_req_type,
  input  logic [i2cbe_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                         in_send_ack,
  input  logic                         in_sda_in,
  input  logic                         in_scl_in,
  output i2cbe_pkg::qhead_t            q_head,
  input  logic                         q_pop
);

  i2cbe_pkg::tick_t                  q_mem_r [i2cbe_pkg::QDEPTH];
  logic [i2cbe_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cbe_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cbe_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              push;
  i2cbe_pkg::cmd_t                   cmd;
  i2cbe_pkg::tick_t                  new_item;

  // codes 5..7 mean nothing; run them as a plain tick
  always_comb begin
    unique case (in_req_type)
      3'd1:    cmd = i2cbe_pkg::CMD_START;
      3'd2:    cmd = i2cbe_pkg::CMD_STOP;
      3'd3:    cmd = i2cbe_pkg::CMD_WRITE;
      3'd4:    cmd = i2cbe_pkg::CMD_READ;
      default: cmd = i2cbe_pkg::CMD_TICK;
    endcase
  end

  assign new_item = '{cmd: cmd, data_byte: in_data_byte, send_ack: in_send_ack,
                      sda_in: in_sda_in, scl_in: in_scl_in};

  assign in_stall = (cnt_r == i2cbe_pkg::QCNT_W'(i2cbe_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### design/i2cbe_back.sv
// ----------------------------------------------------------------------------
// i2cbe_back
// Bus engine: pops one tick per cycle unless the output stalls, steps the
// start/stop/write/read phase sequences and holds the resulting pin and status beat.
// ----------------------------------------------------------------------------
module i2cbe_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  i2cbe_pkg::qhead_t            q_head,
  output logic                         q_pop,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [i2cbe_pkg::DLY_W-1:0]  cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_scl_release,
  output logic                         out_sda_release,
  output logic                         out_busy_res,
  output logic                         out_done_res,
  output logic [i2cbe_pkg::BYTE_W-1:0] out_rx_byte,
  output logic                         out_ack_bit
);

  logic [i2cbe_pkg::DLY_W-1:0]  tpd_r;
  i2cbe_pkg::phase_t            phase_r, phase_nxt;
  logic [i2cbe_pkg::CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt, bit_cnt_inc;
  logic [i2cbe_pkg::BYTE_W-1:0] shift_r, shift_nxt;
  logic [i2cbe_pkg::DLY_W-1:0]  dly_r, dly_nxt, dly_dec, dly_load;
  logic                         dly_end;
  logic                         scl_r, scl_nxt;
  logic                         sda_r, sda_nxt;
  logic [i2cbe_pkg::BYTE_W-1:0] rx_r, rx_nxt;
  logic                         ack_seen_r, ack_seen_nxt;
  logic                         ack_choice_r, ack_choice_nxt;
  logic                         done_r, done_nxt;
  logic                         out_valid_r, out_valid_nxt;
  i2cbe_pkg::tick_t             it;

  assign it        = q_head.item;
  assign cfg_ready = 1'b1;
  assign q_pop     = q_head.valid && (!out_valid_r || !out_stall);

  assign dly_dec     = (dly_r != '0) ? dly_r - 1'b1 : '0;
  assign dly_end     = (dly_dec == '0);
  assign dly_load    = (tpd_r == '0) ? i2cbe_pkg::DLY_W'(1) : tpd_r;
  assign bit_cnt_inc = bit_cnt_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    dly_nxt        = dly_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    rx_nxt         = rx_r;
    ack_seen_nxt   = ack_seen_r;
    ack_choice_nxt = ack_choice_r;
    done_nxt       = 1'b0;
    unique case (phase_r)
      i2cbe_pkg::PH_IDLE: begin
        unique case (it.cmd)
          i2cbe_pkg::CMD_START: begin
            bit_cnt_nxt = '0;
            sda_nxt     = 1'b1;
            dly_nxt     = dly_load;
            phase_nxt   = i2cbe_pkg::PH_ST_A;
          end
          i2cbe_pkg::CMD_STOP: begin
            bit_cnt_nxt = '0;
            sda_nxt     = 1'b0;
            dly_nxt     = dly_load;
            phase_nxt   = i2cbe_pkg::PH_SP_A;
          end
          i2cbe_pkg::CMD_WRITE: begin
            bit_cnt_nxt = '0;
            shift_nxt   = it.data_byte;
            sda_nxt     = it.data_byte[i2cbe_pkg::BYTE_W-1];
            scl_nxt     = 1'b1;
            dly_nxt     = dly_load;
            phase_nxt   = i2cbe_pkg::PH_TX_HIGH;
          end
          i2cbe_pkg::CMD_READ: begin
            bit_cnt_nxt    = '0;
            shift_nxt      = '0;
            ack_choice_nxt = it.send_ack;
            sda_nxt        = 1'b1;
            scl_nxt        = 1'b1;
            phase_nxt      = i2cbe_pkg::PH_RX_WAIT;
          end
          default: begin
          end
        endcase
      end
      i2cbe_pkg::PH_ST_A: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b1;
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_ST_B;
        end
      end
      i2cbe_pkg::PH_ST_B: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          sda_nxt   = 1'b0;
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_ST_C;
        end
      end
      i2cbe_pkg::PH_ST_C: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b0;
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_ST_D;
        end
      end
      i2cbe_pkg::PH_ST_D: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          done_nxt  = 1'b1;
          phase_nxt = i2cbe_pkg::PH_IDLE;
        end
      end
      i2cbe_pkg::PH_SP_A: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b1;
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_SP_B;
        end
      end
      i2cbe_pkg::PH_SP_B: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          sda_nxt   = 1'b1;
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_SP_C;
        end
      end
      i2cbe_pkg::PH_SP_C: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          done_nxt  = 1'b1;
          phase_nxt = i2cbe_pkg::PH_IDLE;
        end
      end
      i2cbe_pkg::PH_TX_HIGH: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          shift_nxt = {shift_r[i2cbe_pkg::BYTE_W-2:0], 1'b0};
          scl_nxt   = 1'b0;
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_TX_LOW;
        end
      end
      i2cbe_pkg::PH_TX_LOW: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          bit_cnt_nxt = bit_cnt_inc;
          scl_nxt     = 1'b1;
          dly_nxt     = dly_load;
          if (bit_cnt_inc < i2cbe_pkg::BITS_PER_BYTE) begin
            sda_nxt   = shift_r[i2cbe_pkg::BYTE_W-1];
            phase_nxt = i2cbe_pkg::PH_TX_HIGH;
          end else begin
            sda_nxt   = 1'b1;   // release for the slave's ack
            phase_nxt = i2cbe_pkg::PH_TX_ACK;
          end
        end
      end
      i2cbe_pkg::PH_TX_ACK: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          ack_seen_nxt = it.sda_in;
          scl_nxt      = 1'b0;
          done_nxt     = 1'b1;
          phase_nxt    = i2cbe_pkg::PH_IDLE;
        end
      end
      i2cbe_pkg::PH_RX_RAISE: begin
        scl_nxt   = 1'b1;
        phase_nxt = i2cbe_pkg::PH_RX_WAIT;
      end
      i2cbe_pkg::PH_RX_WAIT: begin
        if (it.scl_in) begin
          dly_nxt   = dly_load;
          phase_nxt = i2cbe_pkg::PH_RX_HIGH;
        end
      end
      i2cbe_pkg::PH_RX_HIGH: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          shift_nxt   = {shift_r[i2cbe_pkg::BYTE_W-2:0], it.sda_in};
          bit_cnt_nxt = bit_cnt_inc;
          scl_nxt     = 1'b0;
          phase_nxt   = (bit_cnt_inc < i2cbe_pkg::BITS_PER_BYTE) ?
                        i2cbe_pkg::PH_RX_RAISE : i2cbe_pkg::PH_RX_ACK_RAISE;
        end
      end
      i2cbe_pkg::PH_RX_ACK_RAISE: begin
        sda_nxt   = !ack_choice_r;
        scl_nxt   = 1'b1;
        dly_nxt   = dly_load;
        phase_nxt = i2cbe_pkg::PH_RX_ACK_HIGH;
      end
      i2cbe_pkg::PH_RX_ACK_HIGH: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          rx_nxt    = shift_r;
          done_nxt  = 1'b1;
          phase_nxt = i2cbe_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = i2cbe_pkg::PH_IDLE;
      end
    endcase
  end

  // output beat held while stalled; refilled on every pop
  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpd_r        <= i2cbe_pkg::TPD_RESET;
      phase_r      <= i2cbe_pkg::PH_IDLE;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      dly_r        <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      rx_r         <= '0;
      ack_seen_r   <= 1'b1;
      ack_choice_r <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tpd_r <= cfg_data;
      end
      if (q_pop) begin
        phase_r      <= phase_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        dly_r        <= dly_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        rx_r         <= rx_nxt;
        ack_seen_r   <= ack_seen_nxt;
        ack_choice_r <= ack_choice_nxt;
        done_r       <= done_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_release = scl_r;
  assign out_sda_release = sda_r;
  assign out_busy_res    = (phase_r != i2cbe_pkg::PH_IDLE);
  assign out_done_res    = done_r;
  assign out_rx_byte     = rx_r;
  assign out_ack_bit     = ack_seen_r;

endmodule

### design/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Open-drain I2C master engine: start, stop, byte write and byte read with
// ack/nack, paced by a tick stream.
// ----------------------------------------------------------------------------
// Each input beat is one bus timing tick: it carries the sampled SDA and SCL
// levels and, while the engine is idle, an optional command (1 start, 2 stop,
// 3 write byte, 4 read byte; 0 and unused codes are plain ticks). Commands
// arriving while busy, or on the tick a command finishes, are dropped. Every
// input beat yields exactly one output beat with the pin release states, busy,
// a one-tick done pulse, the last received byte and the last write's ack bit.
// Bus delays last cfg_data ticks (written through the cfg port, reset value
// 5, zero behaves as one); write it only while the engine is idle.
// Throughput is one tick per clock while the output is not stalled: the front
// stage queues ticks in a 4-entry queue and the engine retires one queued
// tick per cycle, so the sustained rate is set by the phase update in the
// engine. Each accepted tick is queued, then registered into its output beat
// when popped; in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // tick beats in
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_req_type,
  input  logic [i2cbe_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                         in_send_ack,
  input  logic                         in_sda_in,
  input  logic                         in_scl_in,
  // ticks_per_delay register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [i2cbe_pkg::DLY_W-1:0]  cfg_data,
  // result beats out
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_scl_release,
  output logic                         out_sda_release,
  output logic                         out_busy_res,
  output logic                         out_done_res,
  output logic [i2cbe_pkg::BYTE_W-1:0] out_rx_byte,
  output logic                         out_ack_bit
);

  i2cbe_pkg::qhead_t q_head;
  logic              q_pop;

  // front: classify and queue
  i2cbe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .in_scl_in    (in_scl_in),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  // back: phase engine plus held output beat
  i2cbe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scl_release (out_scl_release),
    .out_sda_release (out_sda_release),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_ack_bit     (out_ack_bit)
  );

endmodule

### design/i2cbe_checker.sv
// ----------------------------------------------------------------------------
// i2cbe_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbe_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_scl_release,
  input logic                         out_sda_release,
  input logic                         out_busy_res,
  input logic                         out_done_res,
  input logic [i2cbe_pkg::BYTE_W-1:0] out_rx_byte,
  input logic                         out_ack_bit
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scl_release) &&
      $stable(out_sda_release) && $stable(out_busy_res) && $stable(out_done_res) &&
      $stable(out_rx_byte) && $stable(out_ack_bit))
    else $error("stalled result beat changed");

  // a finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done with busy still set");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // queue is empty after reset, so the first tick is always taken
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind i2c_master_byte_engine_unit i2cbe_checker u_i2cbe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_scl_release (out_scl_release),
  .out_sda_release (out_sda_release),
  .out_busy_res    (out_busy_res),
  .out_done_res    (out_done_res),
  .out_rx_byte     (out_rx_byte),
  .out_ack_bit     (out_ack_bit)
);
